// ===== rtl/core/uulc_pkg.sv =====
package uulc_pkg;

	localparam int MaxResults = 6;

	localparam logic [7:0] ZeroChar  = 8'h60;
	localparam logic [7:0] SpaceChar = 8'h20;
	localparam logic [7:0] NewLine   = 8'h0A;

	localparam logic ModeEncode = 1'b0;
	localparam logic ModeDecode = 1'b1;

	typedef struct packed {
		logic [7:0] data;
		logic [5:0] line_length;
		logic       first_of_line;
		logic       last_of_line;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  out_value;
		logic        end_of_line;
		logic [13:0] byte_sum;
		logic [5:0]  decoded_count;
	} out_word_t;

	function automatic logic [7:0] enc_char(input logic [5:0] code);
		enc_char = (code == 6'd0) ? ZeroChar : (SpaceChar + {2'b00, code});
	endfunction

	function automatic logic [5:0] dec_char(input logic [7:0] c);
		logic [7:0] diff;
		diff = c - SpaceChar;
		dec_char = (c == ZeroChar || c == SpaceChar) ? 6'd0 : diff[5:0];
	endfunction

endpackage

// ===== rtl/core/uu_line_codec_unit.sv =====
// Line-based uuencode/uudecode unit. cfg_wr_data selects encode (0) or decode (1);
// a write also clears all line state and must only happen while the unit is idle.
// A word is taken into an input register, and one step of logic turns it into
// all of its output words (up to six in encode, up to three in decode), which are
// loaded into a result buffer and drained one per cycle while out_ready is high.
// The single output port draining the result buffer sets the pace of the unit;
// words that produce one or no output word flow at one per cycle while out_ready
// is high. The next input word is taken while the last output word of the
// previous one is being delivered.
module uu_line_codec_unit
	import uulc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);

	logic        mode_q;
	logic        s1_valid_q;
	in_word_t    item_s1;
	logic [23:0] bits_q;
	logic [1:0]  fill_q;
	logic [13:0] sum_q;
	logic [5:0]  rem_q;
	logic [5:0]  lc_q;
	out_word_t   res_q [MaxResults];
	logic [2:0]  res_cnt_q;

	logic        drain_ok;
	logic        proc;
	logic        out_fire;

	out_word_t   res_d [MaxResults];
	logic [2:0]  n_d;
	logic [23:0] bits_d;
	logic [1:0]  fill_d;
	logic [13:0] sum_d;
	logic [5:0]  rem_d;
	logic [5:0]  lc_d;

	assign out_valid = (res_cnt_q != 3'd0);
	assign out_word  = res_q[0];
	assign out_fire  = out_valid && out_ready;
	assign drain_ok  = (res_cnt_q == 3'd0) || (res_cnt_q == 3'd1 && out_ready);
	assign proc      = s1_valid_q && drain_ok;
	assign in_ready  = !s1_valid_q || proc;

	// one word through the codec
	always_comb begin
		logic [5:0]  rem_e;
		logic [1:0]  fill_e;
		logic [23:0] bits_e;
		logic [13:0] sum_e;
		logic [5:0]  lc_e;
		logic        take;
		logic [23:0] shifted;
		logic [23:0] nb;
		logic        emit1;
		logic [1:0]  fill2;
		logic [23:0] bits2;
		logic [13:0] sum2;
		logic [5:0]  rem2;
		logic        grp;
		logic [23:0] gbits;
		logic [2:0]  base;
		logic [2:0]  nl_pos;
		logic [23:0] sb;
		logic [5:0]  tk;
		logic [5:0]  dc;

		for (int i = 0; i < MaxResults; i++) begin
			res_d[i] = '0;
		end
		n_d    = 3'd0;
		bits_d = bits_q;
		fill_d = fill_q;
		sum_d  = sum_q;
		rem_d  = rem_q;
		lc_d   = lc_q;

		rem_e   = item_s1.first_of_line ? item_s1.line_length : rem_q;
		fill_e  = item_s1.first_of_line ? 2'd0 : fill_q;
		bits_e  = item_s1.first_of_line ? 24'd0 : bits_q;
		sum_e   = item_s1.first_of_line ? 14'd0 : sum_q;
		lc_e    = item_s1.first_of_line ? item_s1.line_length : lc_q;
		take    = (rem_e != 6'd0);
		unique case (fill_e)
			2'd0:    shifted = {item_s1.data, 16'd0};
			2'd1:    shifted = {8'd0, item_s1.data, 8'd0};
			2'd2:    shifted = {16'd0, item_s1.data};
			default: shifted = 24'd0;
		endcase
		nb      = bits_e | shifted;
		emit1   = take && (fill_e == 2'd2);
		fill2   = take ? (emit1 ? 2'd0 : fill_e + 2'd1) : fill_e;
		bits2   = take ? (emit1 ? 24'd0 : nb) : bits_e;
		sum2    = take ? (sum_e + {6'd0, item_s1.data}) : sum_e;
		rem2    = take ? (rem_e - 6'd1) : rem_e;
		grp     = emit1 || (item_s1.last_of_line && fill2 != 2'd0);
		gbits   = emit1 ? nb : bits2;
		base    = item_s1.first_of_line ? 3'd1 : 3'd0;
		nl_pos  = base + (grp ? 3'd4 : 3'd0);

		dc = dec_char(item_s1.data);
		sb = {bits_q[17:0], dc};
		tk = (rem_q < 6'd3) ? rem_q : 6'd3;

		if (mode_q == ModeEncode) begin
			if (item_s1.first_of_line) begin
				res_d[0].out_value = SpaceChar + {2'b00, item_s1.line_length};
			end
			if (grp) begin
				for (int k = 0; k < 4; k++) begin
					res_d[3'(base + 3'(k))].out_value = enc_char(gbits[23 - 6*k -: 6]);
				end
			end
			if (item_s1.last_of_line) begin
				res_d[nl_pos].out_value   = NewLine;
				res_d[nl_pos].end_of_line = 1'b1;
				res_d[nl_pos].byte_sum    = sum2;
			end
			n_d = nl_pos + (item_s1.last_of_line ? 3'd1 : 3'd0);
			if (item_s1.last_of_line) begin
				bits_d = 24'd0;
				fill_d = 2'd0;
				sum_d  = 14'd0;
				rem_d  = 6'd0;
				lc_d   = 6'd0;
			end else begin
				bits_d = bits2;
				fill_d = fill2;
				sum_d  = sum2;
				rem_d  = rem2;
				lc_d   = lc_e;
			end
		end else begin
			if (item_s1.first_of_line) begin
				bits_d = 24'd0;
				fill_d = 2'd0;
				sum_d  = 14'd0;
				lc_d   = dc;
				rem_d  = dc;
			end else begin
				if (rem_q != 6'd0) begin
					if (fill_q == 2'd3) begin
						for (int k = 0; k < 3; k++) begin
							res_d[k].out_value     = sb[23 - 8*k -: 8];
							res_d[k].end_of_line   = (rem_q == 6'(k + 1));
							res_d[k].decoded_count = lc_q;
						end
						n_d    = tk[2:0];
						rem_d  = rem_q - tk;
						bits_d = 24'd0;
						fill_d = 2'd0;
					end else begin
						bits_d = sb;
						fill_d = fill_q + 2'd1;
					end
				end
				if (item_s1.last_of_line) begin
					bits_d = 24'd0;
					fill_d = 2'd0;
					rem_d  = 6'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= ModeEncode;
			s1_valid_q <= 1'b0;
			bits_q     <= '0;
			fill_q     <= '0;
			sum_q      <= '0;
			rem_q      <= '0;
			lc_q       <= '0;
			res_cnt_q  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				s1_valid_q <= 1'b1;
			end else if (proc) begin
				s1_valid_q <= 1'b0;
			end

			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
				bits_q <= '0;
				fill_q <= '0;
				sum_q  <= '0;
				rem_q  <= '0;
				lc_q   <= '0;
			end else if (proc) begin
				bits_q <= bits_d;
				fill_q <= fill_d;
				sum_q  <= sum_d;
				rem_q  <= rem_d;
				lc_q   <= lc_d;
			end

			if (proc) begin
				res_cnt_q <= n_d;
			end else if (out_fire) begin
				res_cnt_q <= res_cnt_q - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_word;
		end
		if (proc) begin
			for (int i = 0; i < MaxResults; i++) begin
				res_q[i] <= res_d[i];
			end
		end else if (out_fire) begin
			for (int i = 0; i < MaxResults - 1; i++) begin
				res_q[i] <= res_q[i + 1];
			end
		end
	end

	a_res_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q <= 3'(MaxResults))
		else $error("result buffer count out of range");

	a_enc_fill: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == ModeEncode |-> fill_q != 2'd3)
		else $error("encode group holds a full group");

	a_rem_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= lc_q)
		else $error("bytes remaining exceed line count");

	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q > 3'd1 |=> res_cnt_q == $past(res_cnt_q) ||
			res_cnt_q == $past(res_cnt_q) - 3'd1)
		else $error("result buffer reloaded before draining");

endmodule
